@@ src/sgr_pkg.sv @@
package sgr_pkg;

   localparam int unsigned FIELD_W = 20;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_UPPER_M = 8'h4D;
   localparam logic [7:0] CHAR_LOWER_M = 8'h6D;

   // modifier bits of the code field: shift, meta, control, motion
   localparam logic [FIELD_W-1:0] MOD_MASK   = FIELD_W'(60);
   localparam int unsigned        MOTION_BIT = 5;

   typedef enum logic [1:0] {
      PHASE_CODE = 2'd0,
      PHASE_COL  = 2'd1,
      PHASE_ROW  = 2'd2
   } phase_type;

   typedef struct packed {
      logic               report_valid;
      logic [FIELD_W-1:0] button_code;
      logic               motion;
      logic               release_res;
      logic [FIELD_W-1:0] column;
      logic [FIELD_W-1:0] row_value;
   } rsp_type;

endpackage

@@ src/sgr_if.sv @@
interface sgr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_final;

   modport source (output valid, output data_byte, output is_final, input ready);
   modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface sgr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        report_valid;
   logic [sgr_pkg::FIELD_W-1:0] button_code;
   logic                        motion;
   logic                        release_res;
   logic [sgr_pkg::FIELD_W-1:0] column;
   logic [sgr_pkg::FIELD_W-1:0] row_value;

   modport source (output valid, output report_valid, output button_code, output motion,
                   output release_res, output column, output row_value, input ready);
   modport sink   (input valid, input report_valid, input button_code, input motion,
                   input release_res, input column, input row_value, output ready);
endinterface

@@ src/sgr_parse_core.sv @@
module sgr_parse_core #(
   parameter int unsigned SAT_LIMIT = 100000
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             is_final,
   output logic             result_load,
   output sgr_pkg::rsp_type result
);

   localparam int unsigned ACC_W = $clog2(SAT_LIMIT * 10 + 10);

   sgr_pkg::phase_type phase_ff, phase_in;
   logic               digit_seen_ff, digit_seen_in;
   logic               syntax_error_ff, syntax_error_in;
   logic               string_ended_ff, string_ended_in;
   logic [ACC_W-1:0]   code_acc_ff, code_acc_in;
   logic [ACC_W-1:0]   col_acc_ff, col_acc_in;
   logic [ACC_W-1:0]   row_acc_ff, row_acc_in;

   logic                        is_digit;
   logic [3:0]                  digit;
   logic [ACC_W-1:0]            cur_acc;
   logic [ACC_W-1:0]            next_acc;
   logic                        good_final;
   logic                        report_ok;
   logic [sgr_pkg::FIELD_W-1:0] code_w;

   assign is_digit = (data_byte >= sgr_pkg::CHAR_ZERO) && (data_byte <= sgr_pkg::CHAR_NINE);
   assign digit    = 4'(data_byte - sgr_pkg::CHAR_ZERO);

   // one shared times-ten-plus-digit unit for the field in progress
   always_comb begin
      unique case (phase_ff)
         sgr_pkg::PHASE_CODE: cur_acc = code_acc_ff;
         sgr_pkg::PHASE_COL:  cur_acc = col_acc_ff;
         default:             cur_acc = row_acc_ff;
      endcase
      if (cur_acc <= ACC_W'(SAT_LIMIT)) begin
         next_acc = (cur_acc << 3) + (cur_acc << 1) + ACC_W'(digit);
      end else begin
         next_acc = cur_acc;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      digit_seen_in   = digit_seen_ff;
      syntax_error_in = syntax_error_ff;
      string_ended_in = string_ended_ff;
      code_acc_in     = code_acc_ff;
      col_acc_in      = col_acc_ff;
      row_acc_in      = row_acc_ff;
      if (accept) begin
         if (is_final) begin
            phase_in        = sgr_pkg::PHASE_CODE;
            digit_seen_in   = 1'b0;
            syntax_error_in = 1'b0;
            string_ended_in = 1'b0;
            code_acc_in     = '0;
            col_acc_in      = '0;
            row_acc_in      = '0;
         end else if (!syntax_error_ff && !string_ended_ff) begin
            priority if (data_byte == sgr_pkg::CHAR_NUL) begin
               string_ended_in = 1'b1;
            end else if (is_digit) begin
               digit_seen_in = 1'b1;
               unique case (phase_ff)
                  sgr_pkg::PHASE_CODE: code_acc_in = next_acc;
                  sgr_pkg::PHASE_COL:  col_acc_in  = next_acc;
                  default:             row_acc_in  = next_acc;
               endcase
            end else if (data_byte == sgr_pkg::CHAR_SEMI) begin
               if (!digit_seen_ff || (phase_ff == sgr_pkg::PHASE_ROW)) begin
                  syntax_error_in = 1'b1;
               end else begin
                  phase_in      = (phase_ff == sgr_pkg::PHASE_CODE) ? sgr_pkg::PHASE_COL
                                                                    : sgr_pkg::PHASE_ROW;
                  digit_seen_in = 1'b0;
               end
            end else begin
               syntax_error_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sgr_pkg::PHASE_CODE;
         digit_seen_ff   <= 1'b0;
         syntax_error_ff <= 1'b0;
         string_ended_ff <= 1'b0;
         code_acc_ff     <= '0;
         col_acc_ff      <= '0;
         row_acc_ff      <= '0;
      end else begin
         phase_ff        <= phase_in;
         digit_seen_ff   <= digit_seen_in;
         syntax_error_ff <= syntax_error_in;
         string_ended_ff <= string_ended_in;
         code_acc_ff     <= code_acc_in;
         col_acc_ff      <= col_acc_in;
         row_acc_ff      <= row_acc_in;
      end
   end

   assign good_final = (data_byte == sgr_pkg::CHAR_UPPER_M) ||
                       (data_byte == sgr_pkg::CHAR_LOWER_M);
   assign report_ok  = good_final && !syntax_error_ff && digit_seen_ff &&
                       (phase_ff == sgr_pkg::PHASE_ROW);
   assign code_w     = sgr_pkg::FIELD_W'(code_acc_ff);

   assign result_load = accept && is_final;

   always_comb begin
      result = '0;
      if (report_ok) begin
         result.report_valid = 1'b1;
         result.button_code  = code_w & ~sgr_pkg::MOD_MASK;
         result.motion       = code_w[sgr_pkg::MOTION_BIT];
         result.release_res  = (data_byte == sgr_pkg::CHAR_LOWER_M);
         result.column       = sgr_pkg::FIELD_W'(col_acc_ff);
         result.row_value    = sgr_pkg::FIELD_W'(row_acc_ff);
      end
   end

endmodule

@@ src/sgr_rsp_stage.sv @@
module sgr_rsp_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  sgr_pkg::rsp_type result,
   output logic             can_take,
   sgr_rsp_if.source        rsp_ch
);

   logic             valid_ff, valid_in;
   sgr_pkg::rsp_type data_ff, data_in;

   // a held result drains in the same cycle a new one lands
   assign can_take = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (can_take) begin
         valid_in = load;
         if (load) begin
            data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.report_valid = data_ff.report_valid;
   assign rsp_ch.button_code  = data_ff.button_code;
   assign rsp_ch.motion       = data_ff.motion;
   assign rsp_ch.release_res  = data_ff.release_res;
   assign rsp_ch.column       = data_ff.column;
   assign rsp_ch.row_value    = data_ff.row_value;

endmodule

@@ src/sgr_mouse_report_parser.sv @@
// channel  | dir | payload
// req_ch   | in  | data_byte[7:0], is_final
// rsp_ch   | out | report_valid, button_code[19:0], motion, release_res,
//          |     | column[19:0], row_value[19:0]
//
// One byte per cycle while req_ch.ready is high; a result appears in the cycle after its final byte is taken.
// Parser state and the result register load in the same cycle.
// Synchronous active-high reset clears parser state and the result valid.
// req_ch.ready drops only while a result is held and rsp_ch.ready is low.
module sgr_mouse_report_parser #(
   parameter int unsigned SAT_LIMIT = 100000
) (
   input  logic      clock,
   input  logic      reset,
   sgr_req_if.sink   req_ch,
   sgr_rsp_if.source rsp_ch
);

   logic             accept;
   logic             can_take;
   logic             result_load;
   sgr_pkg::rsp_type result;

   assign req_ch.ready = can_take;
   assign accept       = req_ch.valid && can_take;

   sgr_parse_core #(
      .SAT_LIMIT (SAT_LIMIT)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_ch.data_byte),
      .is_final    (req_ch.is_final),
      .result_load (result_load),
      .result      (result)
   );

   sgr_rsp_stage u_rsp (
      .clock    (clock),
      .reset    (reset),
      .load     (result_load),
      .result   (result),
      .can_take (can_take),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ src/sgr_checker.sv @@
module sgr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_is_final,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_report_valid,
   input logic [sgr_pkg::FIELD_W-1:0] rsp_button_code,
   input logic                        rsp_motion,
   input logic                        rsp_release_res,
   input logic [sgr_pkg::FIELD_W-1:0] rsp_column,
   input logic [sgr_pkg::FIELD_W-1:0] rsp_row_value
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rise_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_is_final))
      else $error("result without a final transaction");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_is_final && (!rsp_valid || rsp_ready))
      |=> !rsp_valid)
      else $error("result from a parameter byte");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_report_valid) |->
      (rsp_button_code == '0 && !rsp_motion && !rsp_release_res &&
       rsp_column == '0 && rsp_row_value == '0))
      else $error("invalid report carries nonzero fields");

endmodule

bind sgr_mouse_report_parser sgr_checker u_sgr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_is_final     (req_ch.is_final),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_report_valid (rsp_ch.report_valid),
   .rsp_button_code  (rsp_ch.button_code),
   .rsp_motion       (rsp_ch.motion),
   .rsp_release_res  (rsp_ch.release_res),
   .rsp_column       (rsp_ch.column),
   .rsp_row_value    (rsp_ch.row_value)
);

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SAT_LIMIT    = 100000;
   localparam int          HOLD_CYCLES  = 120;
   localparam int          PHASE_ITEMS  = 335;
   localparam int          DRAIN_CYCLES = 20;

   localparam int SEND_IDLE  [4] = '{0, 88, 0, 29};
   localparam int RECV_STALL [4] = '{0, 0, 88, 29};

   // invalid report: every result field is cleared
   localparam sgr_pkg::rsp_type REJECT = '0;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             is_final;
      logic             typed;
      sgr_pkg::rsp_type exp_rsp;
   } stim_row_type;

   // typed rows carry their expected report; the rest go through the parser model
   stim_row_type directed_rows [26] = '{
      '{sgr_pkg::CHAR_UPPER_M, 1'b1, 1'b1, REJECT},
      '{"6", 1'b0, 1'b0, '0},
      '{"3", 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_SEMI, 1'b0, 1'b0, '0},
      '{"1", 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_SEMI, 1'b0, 1'b0, '0},
      '{"2", 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_LOWER_M, 1'b1, 1'b1, '{1'b1, 20'd3, 1'b1, 1'b1, 20'd1, 20'd2}},
      '{"1", 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_SEMI, 1'b0, 1'b0, '0},
      '{"2", 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_SEMI, 1'b0, 1'b0, '0},
      '{"3", 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_NUL, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_UPPER_M, 1'b1, 1'b1, '{1'b1, 20'd1, 1'b0, 1'b0, 20'd2, 20'd3}},
      '{sgr_pkg::CHAR_SEMI, 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_UPPER_M, 1'b1, 1'b1, REJECT},
      '{"A", 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_UPPER_M, 1'b1, 1'b1, REJECT},
      '{"0", 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_SEMI, 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0},
      '{sgr_pkg::CHAR_SEMI, 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, REJECT}
   };

   logic clock;
   logic reset;

   sgr_req_if req_ch ();
   sgr_rsp_if rsp_ch ();

   sgr_mouse_report_parser #(
      .SAT_LIMIT(SAT_LIMIT)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // parser model state
   sgr_pkg::phase_type cur_phase  = sgr_pkg::PHASE_CODE;
   logic               got_digit  = 1'b0;
   int unsigned        code_sum   = 0;
   int unsigned        col_sum    = 0;
   int unsigned        row_sum    = 0;
   logic               bad_syntax = 1'b0;
   logic               str_done   = 1'b0;

   sgr_pkg::rsp_type pending_reports [$];
   int               mismatches     = 0;
   int               items_sent     = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   logic             hold_request   = 1'b0;
   logic             row_typed;
   sgr_pkg::rsp_type row_exp;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #600000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int unsigned saturating_push(input int unsigned acc,
                                                   input int unsigned digit);
      return (acc <= SAT_LIMIT) ? acc * 10 + digit : acc;
   endfunction

   task automatic parse_step(input logic [7:0] b, input logic fin,
                             output logic emits, output sgr_pkg::rsp_type rep);
      rep   = '0;
      emits = fin;
      if (!fin) begin
         if (!bad_syntax && !str_done) begin
            if (b == sgr_pkg::CHAR_NUL) begin
               str_done = 1'b1;
            end else if (b >= sgr_pkg::CHAR_ZERO && b <= sgr_pkg::CHAR_NINE) begin
               case (cur_phase)
                  sgr_pkg::PHASE_CODE:
                     code_sum = saturating_push(code_sum, b - sgr_pkg::CHAR_ZERO);
                  sgr_pkg::PHASE_COL:
                     col_sum  = saturating_push(col_sum, b - sgr_pkg::CHAR_ZERO);
                  default:
                     row_sum  = saturating_push(row_sum, b - sgr_pkg::CHAR_ZERO);
               endcase
               got_digit = 1'b1;
            end else if (b == sgr_pkg::CHAR_SEMI) begin
               if (!got_digit || cur_phase == sgr_pkg::PHASE_ROW) begin
                  bad_syntax = 1'b1;
               end else begin
                  cur_phase = (cur_phase == sgr_pkg::PHASE_CODE) ? sgr_pkg::PHASE_COL
                                                                 : sgr_pkg::PHASE_ROW;
                  got_digit = 1'b0;
               end
            end else begin
               bad_syntax = 1'b1;
            end
         end
      end else begin
         if ((b == sgr_pkg::CHAR_UPPER_M || b == sgr_pkg::CHAR_LOWER_M) && !bad_syntax &&
             cur_phase == sgr_pkg::PHASE_ROW && got_digit) begin
            rep.report_valid = 1'b1;
            rep.button_code  = code_sum[sgr_pkg::FIELD_W-1:0] & ~sgr_pkg::MOD_MASK;
            rep.motion       = code_sum[sgr_pkg::MOTION_BIT];
            rep.release_res  = (b == sgr_pkg::CHAR_LOWER_M);
            rep.column       = col_sum[sgr_pkg::FIELD_W-1:0];
            rep.row_value    = row_sum[sgr_pkg::FIELD_W-1:0];
         end
         cur_phase  = sgr_pkg::PHASE_CODE;
         got_digit  = 1'b0;
         code_sum   = 0;
         col_sum    = 0;
         row_sum    = 0;
         bad_syntax = 1'b0;
         str_done   = 1'b0;
      end
   endtask

   task automatic check_field(input string what, input logic [sgr_pkg::FIELD_W-1:0] want,
                              input logic [sgr_pkg::FIELD_W-1:0] got);
      if (want !== got) begin
         if (mismatches < 10)
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch_ports
      sgr_pkg::rsp_type got, want, model;
      logic             emits;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{report_valid: rsp_ch.report_valid, button_code: rsp_ch.button_code,
                    motion: rsp_ch.motion, release_res: rsp_ch.release_res,
                    column: rsp_ch.column, row_value: rsp_ch.row_value};
            if (pending_reports.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: report with none pending: %p", $time, got);
               mismatches++;
            end else begin
               want = pending_reports.pop_front();
               check_field("report_valid", want.report_valid, got.report_valid);
               check_field("button_code", want.button_code, got.button_code);
               check_field("motion", want.motion, got.motion);
               check_field("release_res", want.release_res, got.release_res);
               check_field("column", want.column, got.column);
               check_field("row_value", want.row_value, got.row_value);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            parse_step(req_ch.data_byte, req_ch.is_final, emits, model);
            if (emits)
               pending_reports.push_back(row_typed ? row_exp : model);
         end
      end
   end

   // receiver: random stalls plus one long hold-off on request
   initial begin : rsp_side
      int   hold_left;
      logic hold_served;
      hold_left   = 0;
      hold_served = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // called just after a rising edge; returns at the edge where the transaction is taken
   task automatic send_item(input logic [7:0] b, input logic fin,
                            input logic typed = 1'b0, input sgr_pkg::rsp_type exp_rsp = '0);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.is_final  <= fin;
      row_typed        <= typed;
      row_exp          <= exp_rsp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_all_reports();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed reports with random digits; some cut short, broken or pure noise
   task automatic send_report();
      int         kind, f, cut, ndig;
      logic [7:0] fin_byte;
      kind = $urandom_range(0, 9);
      cut  = $urandom_range(0, 3);
      if (kind == 9) begin
         repeat ($urandom_range(1, 8)) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         for (f = 0; f < 3; f++) begin
            if (kind == 7 && f == cut) begin
               send_item(sgr_pkg::CHAR_NUL, 1'b0);
               repeat ($urandom_range(0, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            // long fields run into saturation
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            if (kind == 8 && $urandom_range(0, 3) == 0)
               ndig = 0;
            repeat (ndig) send_item(8'(sgr_pkg::CHAR_ZERO + $urandom_range(0, 9)), 1'b0);
            if (f < 2)
               send_item(sgr_pkg::CHAR_SEMI, 1'b0);
            if (kind == 8 && $urandom_range(0, 2) == 0)
               send_item(($urandom_range(0, 1) == 0) ? sgr_pkg::CHAR_SEMI
                                                     : 8'($urandom_range(0, 255)), 1'b0);
         end
         if (kind == 7 && cut == 3)
            send_item(sgr_pkg::CHAR_NUL, 1'b0);
      end
      if ($urandom_range(0, 9) != 0)
         fin_byte = ($urandom_range(0, 1) == 0) ? sgr_pkg::CHAR_UPPER_M : sgr_pkg::CHAR_LOWER_M;
      else
         fin_byte = 8'($urandom_range(0, 255));
      send_item(fin_byte, 1'b1);
   endtask

   initial begin : stimulus
      int ph, phase_start;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.is_final  = 1'b0;
      row_typed        = 1'b0;
      row_exp          = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].data_byte, directed_rows[i].is_final,
                   directed_rows[i].typed, directed_rows[i].exp_rsp);
      wait_all_reports();

      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = SEND_IDLE[ph];
         recv_stall_pct = RECV_STALL[ph];
         // long receiver hold-off while the sender keeps pushing
         if (ph == 0)
            hold_request <= 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS)
            send_report();
         wait_all_reports();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
